// File: rtl/core/i2cms_pkg.sv
package i2cms_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned PHASE_W       = 4;
  localparam int unsigned BIT_W         = 4;
  localparam int unsigned TPDU_W        = 16;
  localparam int unsigned DELAY_W       = 19;
  localparam int unsigned CFG_ADDR_W    = 3;
  localparam int unsigned CFG_DATA_W    = 32;

  // Request kinds; the tick code doubles as the idle command
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  // Phase lengths in delay units
  typedef enum logic [2:0] {
    UNITS_1 = 3'd1,
    UNITS_2 = 3'd2,
    UNITS_6 = 3'd6
  } units_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TICKS_PER_UNIT = 1'b0
  } reg_idx_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       active_bus;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
    logic       rejected;
  } result_t;

endpackage

// File: rtl/core/i2cms_if.sv
interface i2cms_in_if;
  logic                            valid;
  logic                            ready;
  logic [i2cms_pkg::KIND_W-1:0]    kind;
  logic                            bus;
  logic [7:0]                      write_byte;
  logic                            send_ack;
  logic                            sda_in;

  modport source (output valid, kind, bus, write_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, kind, bus, write_byte, send_ack, sda_in, output ready);
endinterface

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       active_bus;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_seen;
  logic       rejected;

  modport source (output valid, scl_out, sda_out, active_bus, busy_res, done_res,
                  read_byte, ack_seen, rejected, input ready);
  modport sink   (input valid, scl_out, sda_out, active_bus, busy_res, done_res,
                  read_byte, ack_seen, rejected, output ready);
endinterface

// File: rtl/core/i2cms_cfg.sv
module i2cms_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [i2cms_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [i2cms_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready,
  output logic [i2cms_pkg::TPDU_W-1:0]        ticks_per_unit
);

  logic [i2cms_pkg::TPDU_W-1:0] tpdu_r;
  logic                         sel_tpdu;
  logic                         wr_en;

  assign cfg_pready = 1'b1;
  assign sel_tpdu   = (cfg_paddr[i2cms_pkg::CFG_ADDR_W-1] == i2cms_pkg::REG_TICKS_PER_UNIT);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpdu_r <= i2cms_pkg::TPDU_W'(1);
    end else if (wr_en && sel_tpdu) begin
      tpdu_r <= cfg_pwdata[i2cms_pkg::TPDU_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_tpdu) begin
      cfg_prdata = {{(i2cms_pkg::CFG_DATA_W-i2cms_pkg::TPDU_W){1'b0}}, tpdu_r};
    end
  end

  assign ticks_per_unit = tpdu_r;

endmodule

// File: rtl/core/i2cms_seq.sv
module i2cms_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [i2cms_pkg::KIND_W-1:0]      kind,
  input  logic                              bus,
  input  logic [7:0]                        write_byte,
  input  logic                              send_ack,
  input  logic                              sda_in,
  input  logic [i2cms_pkg::TPDU_W-1:0]      ticks_per_unit,
  output i2cms_pkg::result_t                result
);

  i2cms_pkg::kind_t                     cmd_r, cmd_nxt;
  logic [i2cms_pkg::PHASE_W-1:0]        phase_r, phase_nxt;
  logic [i2cms_pkg::BIT_W-1:0]          bit_r, bit_nxt;
  logic [i2cms_pkg::DELAY_W-1:0]        delay_r, delay_nxt;
  logic [7:0]                           shift_r, shift_nxt;
  logic                                 scl_r, scl_nxt;
  logic                                 sda_r, sda_nxt;
  logic                                 bus_r, bus_nxt;
  logic                                 ack_r, ack_nxt;
  logic                                 ack_send_r, ack_send_nxt;
  logic [7:0]                           last_rd_r, last_rd_nxt;

  logic                                 run;
  logic                                 smp;
  logic                                 done;
  logic                                 rej;
  logic [i2cms_pkg::DELAY_W-1:0]        dl;
  logic [i2cms_pkg::PHASE_W-1:0]        last_ph;
  logic [i2cms_pkg::PHASE_W-1:0]        loop_end;
  i2cms_pkg::units_t                    units;
  logic [i2cms_pkg::DELAY_W-1:0]        unit_ticks;

  // A zero unit length counts as one tick
  assign unit_ticks = (ticks_per_unit == '0) ? i2cms_pkg::DELAY_W'(1)
                                             : i2cms_pkg::DELAY_W'(ticks_per_unit);

  always_comb begin
    cmd_nxt      = cmd_r;
    phase_nxt    = phase_r;
    bit_nxt      = bit_r;
    delay_nxt    = delay_r;
    shift_nxt    = shift_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    bus_nxt      = bus_r;
    ack_nxt      = ack_r;
    ack_send_nxt = ack_send_r;
    last_rd_nxt  = last_rd_r;
    run          = 1'b0;
    smp          = 1'b0;
    done         = 1'b0;
    rej          = 1'b0;
    units        = i2cms_pkg::UNITS_2;
    dl           = delay_r - i2cms_pkg::DELAY_W'(delay_r != '0);

    last_ph  = ((cmd_r == i2cms_pkg::KIND_START) || (cmd_r == i2cms_pkg::KIND_STOP))
               ? i2cms_pkg::PHASE_W'(2) : i2cms_pkg::PHASE_W'(6);
    loop_end = '1;
    if (cmd_r == i2cms_pkg::KIND_WRITE) loop_end = i2cms_pkg::PHASE_W'(2);
    if (cmd_r == i2cms_pkg::KIND_READ)  loop_end = i2cms_pkg::PHASE_W'(3);

    if (accept) begin
      if (kind == i2cms_pkg::KIND_TICK) begin
        if (cmd_r != i2cms_pkg::KIND_TICK) begin
          delay_nxt = dl;
          smp       = sda_in;
          if (dl == '0) begin
            // Loop back over the bit phases until the last bit is through
            if (phase_r == loop_end &&
                bit_r < i2cms_pkg::BIT_W'(i2cms_pkg::BITS_PER_BYTE - 1)) begin
              bit_nxt   = bit_r + 1'b1;
              phase_nxt = '0;
              run       = 1'b1;
            end else if (phase_r >= last_ph) begin
              if (cmd_r == i2cms_pkg::KIND_READ) last_rd_nxt = shift_r;
              cmd_nxt   = i2cms_pkg::KIND_TICK;
              phase_nxt = '0;
              bit_nxt   = '0;
              done      = 1'b1;
            end else begin
              phase_nxt = phase_r + 1'b1;
              run       = 1'b1;
            end
          end
        end
      end else if (kind == i2cms_pkg::KIND_START || kind == i2cms_pkg::KIND_STOP ||
                   kind == i2cms_pkg::KIND_WRITE || kind == i2cms_pkg::KIND_READ) begin
        if (cmd_r != i2cms_pkg::KIND_TICK) begin
          rej = 1'b1;
        end else begin
          cmd_nxt   = i2cms_pkg::kind_t'(kind);
          bus_nxt   = bus;
          phase_nxt = '0;
          bit_nxt   = '0;
          if (kind == i2cms_pkg::KIND_WRITE) shift_nxt = write_byte;
          if (kind == i2cms_pkg::KIND_READ) begin
            shift_nxt    = '0;
            ack_send_nxt = send_ack;
          end
          run = 1'b1;
        end
      end
    end

    if (run) begin
      case (cmd_nxt)
        i2cms_pkg::KIND_START: begin
          case (phase_nxt)
            4'd0:    begin sda_nxt = 1'b1; scl_nxt = 1'b1; end
            4'd1:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        i2cms_pkg::KIND_STOP: begin
          case (phase_nxt)
            4'd0:    sda_nxt = 1'b0;
            4'd1:    scl_nxt = 1'b1;
            default: begin sda_nxt = 1'b1; units = i2cms_pkg::UNITS_6; end
          endcase
        end
        i2cms_pkg::KIND_WRITE: begin
          case (phase_nxt)
            4'd0: begin
              sda_nxt   = shift_nxt[7];
              shift_nxt = {shift_nxt[6:0], 1'b0};
            end
            4'd1:    scl_nxt = 1'b1;
            4'd2:    scl_nxt = 1'b0;
            4'd3:    sda_nxt = 1'b1;
            4'd4:    begin scl_nxt = 1'b1; units = i2cms_pkg::UNITS_1; end
            4'd5:    begin ack_nxt = ~smp; units = i2cms_pkg::UNITS_1; end
            default: scl_nxt = 1'b0;
          endcase
        end
        default: begin
          case (phase_nxt)
            4'd0:    sda_nxt = 1'b1;
            4'd1:    begin scl_nxt = 1'b1; units = i2cms_pkg::UNITS_1; end
            4'd2: begin
              shift_nxt = {shift_nxt[6:0], smp};
              units     = i2cms_pkg::UNITS_1;
            end
            4'd3:    scl_nxt = 1'b0;
            4'd4:    sda_nxt = ~ack_send_nxt;
            4'd5:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
      endcase

      case (units)
        i2cms_pkg::UNITS_1: delay_nxt = unit_ticks;
        i2cms_pkg::UNITS_6: delay_nxt = (unit_ticks << 2) + (unit_ticks << 1);
        default:            delay_nxt = unit_ticks << 1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r      <= i2cms_pkg::KIND_TICK;
      phase_r    <= '0;
      bit_r      <= '0;
      delay_r    <= '0;
      shift_r    <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      bus_r      <= 1'b0;
      ack_r      <= 1'b0;
      ack_send_r <= 1'b0;
      last_rd_r  <= '0;
    end else begin
      cmd_r      <= cmd_nxt;
      phase_r    <= phase_nxt;
      bit_r      <= bit_nxt;
      delay_r    <= delay_nxt;
      shift_r    <= shift_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      bus_r      <= bus_nxt;
      ack_r      <= ack_nxt;
      ack_send_r <= ack_send_nxt;
      last_rd_r  <= last_rd_nxt;
    end
  end

  always_comb begin
    result.scl_out    = scl_nxt;
    result.sda_out    = sda_nxt;
    result.active_bus = bus_nxt;
    result.busy_res   = (cmd_nxt != i2cms_pkg::KIND_TICK);
    result.done_res   = done;
    result.read_byte  = last_rd_nxt;
    result.ack_seen   = ack_nxt;
    result.rejected   = rej;
  end

endmodule

// File: rtl/core/i2c_master_bit_sequencer.sv
// Bit-banged I2C master sequencer for two open-drain pin pairs.
// Input channel in_ch: each request is a tick (carrying the sampled SDA
// level) or a command: start, stop, write byte or read byte. Commands that
// arrive while a sequence is running are dropped and flagged as rejected.
// Output channel out_ch: exactly one result per request, giving the pin
// levels, latched bus, busy/done flags, last read byte and acknowledge seen.
// Config port cfg_*: register 0 at byte address 0 sets the ticks per delay
// unit (reset 1, zero counts as one); write it only while idle.
// The result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle; the phase update is a single pass of
// logic from the sequencer state registers into the result register.
// When the receiver stalls, the result register holds and in_ch.ready drops
// until the held result is taken; a request is taken in the same cycle the
// held result leaves.
// Reset (synchronous, rst_n low): sequencer idle, both lines released,
// no result pending.
module i2c_master_bit_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  i2cms_in_if.sink                            in_ch,
  i2cms_out_if.source                         out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [i2cms_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [i2cms_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  logic                         accept;
  logic                         out_valid_r;
  i2cms_pkg::result_t           res;
  i2cms_pkg::result_t           res_r;
  logic [i2cms_pkg::TPDU_W-1:0] ticks_per_unit;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  i2cms_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready),
    .ticks_per_unit (ticks_per_unit)
  );

  i2cms_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .kind           (in_ch.kind),
    .bus            (in_ch.bus),
    .write_byte     (in_ch.write_byte),
    .send_ack       (in_ch.send_ack),
    .sda_in         (in_ch.sda_in),
    .ticks_per_unit (ticks_per_unit),
    .result         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  // Load the result with each accepted request; hold it while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_out    = res_r.scl_out;
  assign out_ch.sda_out    = res_r.sda_out;
  assign out_ch.active_bus = res_r.active_bus;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.read_byte  = res_r.read_byte;
  assign out_ch.ack_seen   = res_r.ack_seen;
  assign out_ch.rejected   = res_r.rejected;

endmodule

// File: dv/i2cms_pin_checker.sv
module i2cms_pin_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  i2cms_in_if                                 in_mon,
  i2cms_out_if                                out_mon,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic                                cfg_pready,
  input  logic [i2cms_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output int unsigned                         fail_count,
  output int unsigned                         due_count,
  output logic                                seq_busy
);

  // Shadow sequencer state
  i2cms_pkg::kind_t                   seq_cmd;
  logic [i2cms_pkg::PHASE_W-1:0]      seq_phase;
  logic [i2cms_pkg::BIT_W-1:0]        seq_bit;
  logic [i2cms_pkg::DELAY_W-1:0]      seq_wait;
  logic [7:0]                         seq_shift;
  logic                               scl_drv;
  logic                               sda_drv;
  logic                               bus_sel;
  logic                               ack_got;
  logic                               ack_reply;
  logic [7:0]                         rd_last;
  logic [i2cms_pkg::TPDU_W-1:0]       unit_cfg;

  i2cms_pkg::result_t                 due_status[$];
  int unsigned                        n_fail = 0;
  int unsigned                        n_seen = 0;

  assign fail_count = n_fail;

  task automatic reset_model();
    seq_cmd   = i2cms_pkg::KIND_TICK;
    seq_phase = '0;
    seq_bit   = '0;
    seq_wait  = '0;
    seq_shift = '0;
    scl_drv   = 1'b1;
    sda_drv   = 1'b1;
    bus_sel   = 1'b0;
    ack_got   = 1'b0;
    ack_reply = 1'b0;
    rd_last   = '0;
    unit_cfg  = i2cms_pkg::TPDU_W'(1);
  endtask

  // Drive or sample for the current phase and return how long it lasts
  function automatic i2cms_pkg::units_t do_phase(input logic sample);
    i2cms_pkg::units_t u;
    u = i2cms_pkg::UNITS_2;
    case (seq_cmd)
      i2cms_pkg::KIND_START: begin
        case (seq_phase)
          0: begin
            sda_drv = 1'b1;
            scl_drv = 1'b1;
          end
          1: sda_drv = 1'b0;
          default: scl_drv = 1'b0;
        endcase
      end
      i2cms_pkg::KIND_STOP: begin
        case (seq_phase)
          0: sda_drv = 1'b0;
          1: scl_drv = 1'b1;
          default: begin
            sda_drv = 1'b1;
            u = i2cms_pkg::UNITS_6;
          end
        endcase
      end
      i2cms_pkg::KIND_WRITE: begin
        case (seq_phase)
          0: begin
            sda_drv   = seq_shift[7];
            seq_shift = {seq_shift[6:0], 1'b0};
          end
          1: scl_drv = 1'b1;
          2: scl_drv = 1'b0;
          3: sda_drv = 1'b1;
          4: begin
            scl_drv = 1'b1;
            u = i2cms_pkg::UNITS_1;
          end
          5: begin
            ack_got = ~sample;
            u = i2cms_pkg::UNITS_1;
          end
          default: scl_drv = 1'b0;
        endcase
      end
      default: begin
        case (seq_phase)
          0: sda_drv = 1'b1;
          1: begin
            scl_drv = 1'b1;
            u = i2cms_pkg::UNITS_1;
          end
          2: begin
            seq_shift = {seq_shift[6:0], sample};
            u = i2cms_pkg::UNITS_1;
          end
          3: scl_drv = 1'b0;
          4: sda_drv = ~ack_reply;
          5: scl_drv = 1'b1;
          default: scl_drv = 1'b0;
        endcase
      end
    endcase
    return u;
  endfunction

  // Step to the next phase, looping back per bit; 0 once the sequence is over
  function automatic logic advance_phase();
    logic [i2cms_pkg::PHASE_W-1:0] last_ph;
    logic                          bit_loop;
    last_ph  = (seq_cmd == i2cms_pkg::KIND_START || seq_cmd == i2cms_pkg::KIND_STOP)
               ? i2cms_pkg::PHASE_W'(2) : i2cms_pkg::PHASE_W'(6);
    bit_loop = (seq_cmd == i2cms_pkg::KIND_WRITE && seq_phase == 2) ||
               (seq_cmd == i2cms_pkg::KIND_READ && seq_phase == 3);
    if (bit_loop && seq_bit < i2cms_pkg::BITS_PER_BYTE - 1) begin
      seq_bit++;
      seq_phase = '0;
      return 1'b1;
    end
    if (seq_phase >= last_ph) return 1'b0;
    seq_phase++;
    return 1'b1;
  endfunction

  function automatic void arm_wait(input i2cms_pkg::units_t u);
    int unsigned per_unit;
    // a zero setting behaves as one tick per unit
    per_unit = (unit_cfg == 0) ? 1 : int'(unit_cfg);
    seq_wait = i2cms_pkg::DELAY_W'(int'(u) * per_unit);
  endfunction

  function automatic i2cms_pkg::result_t sequence_step(
    input logic [i2cms_pkg::KIND_W-1:0] kind,
    input logic                         bus,
    input logic [7:0]                   wbyte,
    input logic                         sack,
    input logic                         sda
  );
    i2cms_pkg::result_t r;
    logic               done;
    logic               rej;
    done = 1'b0;
    rej  = 1'b0;
    if (kind == i2cms_pkg::KIND_TICK) begin
      if (seq_cmd != i2cms_pkg::KIND_TICK) begin
        if (seq_wait != 0) seq_wait--;
        if (seq_wait == 0) begin
          if (advance_phase()) begin
            arm_wait(do_phase(sda));
          end else begin
            if (seq_cmd == i2cms_pkg::KIND_READ) rd_last = seq_shift;
            seq_cmd   = i2cms_pkg::KIND_TICK;
            seq_phase = '0;
            seq_bit   = '0;
            done      = 1'b1;
          end
        end
      end
    end else if (kind <= i2cms_pkg::KIND_READ) begin
      if (seq_cmd != i2cms_pkg::KIND_TICK) begin
        rej = 1'b1;
      end else begin
        seq_cmd   = i2cms_pkg::kind_t'(kind);
        bus_sel   = bus;
        seq_phase = '0;
        seq_bit   = '0;
        if (seq_cmd == i2cms_pkg::KIND_WRITE) seq_shift = wbyte;
        if (seq_cmd == i2cms_pkg::KIND_READ) begin
          seq_shift = '0;
          ack_reply = sack;
        end
        arm_wait(do_phase(1'b0));
      end
    end
    r.scl_out    = scl_drv;
    r.sda_out    = sda_drv;
    r.active_bus = bus_sel;
    r.busy_res   = (seq_cmd != i2cms_pkg::KIND_TICK);
    r.done_res   = done;
    r.read_byte  = rd_last;
    r.ack_seen   = ack_got;
    r.rejected   = rej;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    n_fail++;
  endtask

  task automatic check_field(input string name, input int unsigned idx,
                             input logic [7:0] seen_v, input logic [7:0] want_v);
    if (seen_v !== want_v)
      flag_mismatch($sformatf("result %0d: %s is 0x%0h, want 0x%0h",
                              idx, name, seen_v, want_v));
  endtask

  always @(posedge clk) begin
    i2cms_pkg::result_t seen;
    i2cms_pkg::result_t want;
    if (!rst_n) begin
      reset_model();
      due_status.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        n_seen++;
        seen.scl_out    = out_mon.scl_out;
        seen.sda_out    = out_mon.sda_out;
        seen.active_bus = out_mon.active_bus;
        seen.busy_res   = out_mon.busy_res;
        seen.done_res   = out_mon.done_res;
        seen.read_byte  = out_mon.read_byte;
        seen.ack_seen   = out_mon.ack_seen;
        seen.rejected   = out_mon.rejected;
        if (due_status.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing outstanding", n_seen));
        end else begin
          want = due_status.pop_front();
          check_field("scl_out", n_seen, 8'(seen.scl_out), 8'(want.scl_out));
          check_field("sda_out", n_seen, 8'(seen.sda_out), 8'(want.sda_out));
          check_field("active_bus", n_seen, 8'(seen.active_bus), 8'(want.active_bus));
          check_field("busy_res", n_seen, 8'(seen.busy_res), 8'(want.busy_res));
          check_field("done_res", n_seen, 8'(seen.done_res), 8'(want.done_res));
          check_field("read_byte", n_seen, seen.read_byte, want.read_byte);
          check_field("ack_seen", n_seen, 8'(seen.ack_seen), 8'(want.ack_seen));
          check_field("rejected", n_seen, 8'(seen.rejected), 8'(want.rejected));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == i2cms_pkg::CFG_ADDR_W'(4 * int'(i2cms_pkg::REG_TICKS_PER_UNIT)))
        unit_cfg = cfg_pwdata[i2cms_pkg::TPDU_W-1:0];
      if (in_mon.valid && in_mon.ready)
        due_status.push_back(sequence_step(in_mon.kind, in_mon.bus, in_mon.write_byte,
                                           in_mon.send_ack, in_mon.sda_in));
    end
    due_count <= due_status.size();
    seq_busy  <= (seq_cmd != i2cms_pkg::KIND_TICK);
  end

endmodule

// File: dv/tb_i2c_master_bit_sequencer.sv
module tb_i2c_master_bit_sequencer;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam logic [i2cms_pkg::KIND_W-1:0] KIND_RSVD_LO = 3'd5;
  localparam logic [i2cms_pkg::KIND_W-1:0] KIND_RSVD_HI = 3'd7;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_psel;
  logic                               cfg_penable;
  logic                               cfg_pwrite;
  logic [i2cms_pkg::CFG_ADDR_W-1:0]   cfg_paddr;
  logic [i2cms_pkg::CFG_DATA_W-1:0]   cfg_pwdata;
  logic [i2cms_pkg::CFG_DATA_W-1:0]   cfg_prdata;
  logic                               cfg_pready;

  int unsigned           fail_count;
  int unsigned           due_count;
  logic                  seq_busy;

  int unsigned           burst_left;
  int unsigned           sent_reqs;
  int unsigned           unit_ticks;
  int unsigned           hold_asked;
  bit                    tx_on;
  bit                    tx_free;
  bit                    rx_free;

  i2cms_in_if  in_if ();
  i2cms_out_if out_if ();

  i2c_master_bit_sequencer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  i2cms_pin_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .due_count   (due_count),
    .seq_busy    (seq_busy)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Offer one request, opening a new burst after a random gap when the last one ran out
  task automatic send_req(input logic [i2cms_pkg::KIND_W-1:0] k, input logic b,
                          input logic [7:0] wb, input logic sa, input logic sd);
    if (burst_left == 0) begin
      if (tx_on) in_if.valid <= 1'b0;
      tx_on = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if (tx_free) burst_left = 1000000;
      else if ($urandom_range(0, 7) == 0) burst_left = 150;
      else burst_left = $urandom_range(1, 24);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= k;
    in_if.bus        <= b;
    in_if.write_byte <= wb;
    in_if.send_ack   <= sa;
    in_if.sda_in     <= sd;
    tx_on = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    sent_reqs++;
  endtask

  task automatic send_rand_req(input logic [i2cms_pkg::KIND_W-1:0] k);
    send_req(k, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_tick();
    send_rand_req(i2cms_pkg::KIND_TICK);
  endtask

  task automatic go_quiet();
    if (tx_on) in_if.valid <= 1'b0;
    tx_on = 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drain();
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
  endtask

  // Tick the running command to its end and collect every result
  task automatic settle();
    go_quiet();
    wait_drain();
    while (seq_busy) send_tick();
    go_quiet();
    wait_drain();
  endtask

  task automatic cfg_write(input logic [i2cms_pkg::CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= i2cms_pkg::CFG_ADDR_W'(4 * int'(i2cms_pkg::REG_TICKS_PER_UNIT));
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    unit_ticks = 32'(value[i2cms_pkg::TPDU_W-1:0]);
  endtask

  // Mostly whole commands with enough ticks to finish, plus cut-short runs and stray requests
  task automatic run_traffic(input int unsigned quota);
    int unsigned stop_at;
    int unsigned need;
    int unsigned ticks;
    int unsigned pick;
    logic [i2cms_pkg::KIND_W-1:0] k;
    stop_at = sent_reqs + quota;
    while (sent_reqs < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) k = i2cms_pkg::KIND_START;
      else if (pick < 4) k = i2cms_pkg::KIND_STOP;
      else if (pick < 7) k = i2cms_pkg::KIND_WRITE;
      else k = i2cms_pkg::KIND_READ;
      send_rand_req(k);
      // total delay units of the whole sequence
      case (k)
        i2cms_pkg::KIND_START: need = 6;
        i2cms_pkg::KIND_STOP:  need = 10;
        default:               need = 54;
      endcase
      need = need * ((unit_ticks == 0) ? 1 : unit_ticks);
      if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, need);
      else ticks = need + $urandom_range(0, 2);
      repeat (ticks) begin
        if ($urandom_range(0, 29) == 0)
          send_rand_req(i2cms_pkg::KIND_W'($urandom_range(1, 7)));
        send_tick();
      end
    end
  endtask

  // Receiver: random ready pattern, free-running, or one long hold-off on request
  initial begin
    int unsigned run_len;
    int unsigned holds_done;
    holds_done = 0;
    out_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_asked != holds_done) begin
        holds_done = hold_asked;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_free) begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run_len = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 10);
        out_if.ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        run_len = $urandom_range(0, 5);
        if (run_len != 0) begin
          out_if.ready <= 1'b0;
          repeat (run_len) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_if.valid      = 1'b0;
    in_if.kind       = i2cms_pkg::KIND_TICK;
    in_if.bus        = 1'b0;
    in_if.write_byte = '0;
    in_if.send_ack   = 1'b0;
    in_if.sda_in     = 1'b1;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    rst_n            = 1'b0;
    tx_on            = 1'b0;
    tx_free          = 1'b0;
    rx_free          = 1'b0;
    burst_left       = 0;
    sent_reqs        = 0;
    hold_asked       = 0;
    unit_ticks       = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // idle tick, reserved kinds, then a start run to completion
    send_req(i2cms_pkg::KIND_TICK, 1'b1, 8'hFF, 1'b1, 1'b0);
    send_req(KIND_RSVD_HI, 1'b1, 8'hFF, 1'b1, 1'b1);
    send_req(KIND_RSVD_LO, 1'b0, 8'h00, 1'b0, 1'b0);
    send_req(i2cms_pkg::KIND_START, 1'b1, 8'h00, 1'b0, 1'b1);
    repeat (6) send_tick();
    // stop, with commands landing while it runs
    send_req(i2cms_pkg::KIND_STOP, 1'b0, 8'h00, 1'b0, 1'b0);
    send_req(i2cms_pkg::KIND_WRITE, 1'b1, 8'hFF, 1'b1, 1'b0);
    send_req(i2cms_pkg::KIND_READ, 1'b0, 8'h00, 1'b1, 1'b1);
    send_req(i2cms_pkg::KIND_START, 1'b1, 8'h5A, 1'b0, 1'b1);
    repeat (10) send_tick();
    settle();

    // receiver holds off while requests keep coming
    hold_asked++;
    run_traffic(300);
    settle();
    run_traffic(150);

    // zero setting, upper data bits set
    settle();
    cfg_write(32'hFFFF_0000);
    run_traffic(300);

    settle();
    cfg_write(32'd3);
    run_traffic(300);

    settle();
    cfg_write(32'd2);
    rx_free = 1'b1;
    tx_free = 1'b1;
    run_traffic(200);
    go_quiet();
    tx_free = 1'b0;
    rx_free = 1'b0;

    settle();
    cfg_write(32'd1);
    run_traffic(150);

    // widest delay: start a stop and tick into its long first phase while commands land
    settle();
    cfg_write(32'h0000_FFFF);
    rx_free = 1'b1;
    tx_free = 1'b1;
    send_rand_req(i2cms_pkg::KIND_STOP);
    repeat (60) begin
      if ($urandom_range(0, 9) == 0)
        send_rand_req(i2cms_pkg::KIND_W'($urandom_range(1, 7)));
      send_tick();
    end

    go_quiet();
    wait_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
